// ===== design/tli_pkg.sv =====
// Shared types, codes and arithmetic helpers for the table linear interpolator.
package tli_pkg;

	localparam int DW = 32;
	localparam int EW = DW + 1;
	localparam int PW = 2 * EW;
	localparam int SW = EW + 3;
	localparam int CW = 7;
	localparam int OP_W = 5;

	localparam logic [CW-1:0] MUL_STEPS  = CW'(EW);
	localparam logic [CW-1:0] GDIV_STEPS = CW'(EW);
	localparam logic [CW-1:0] IDIV_STEPS = CW'(PW);

	localparam logic [1:0] REQ_LOAD_X = 2'd0;
	localparam logic [1:0] REQ_LOAD_F = 2'd1;
	localparam logic [1:0] REQ_QUERY  = 2'd2;

	localparam logic [1:0] REG_POINT_COUNT  = 2'd0;
	localparam logic [1:0] REG_GRID_MODE    = 2'd1;
	localparam logic [1:0] REG_REVERSE_MODE = 2'd2;

	localparam logic [OP_W-1:0] OP_NOP  = 5'd0;
	localparam logic [OP_W-1:0] OP_GA   = 5'd1;
	localparam logic [OP_W-1:0] OP_GB   = 5'd2;
	localparam logic [OP_W-1:0] OP_GC   = 5'd3;
	localparam logic [OP_W-1:0] OP_DIV  = 5'd4;
	localparam logic [OP_W-1:0] OP_GFIN = 5'd5;
	localparam logic [OP_W-1:0] OP_SA   = 5'd6;
	localparam logic [OP_W-1:0] OP_SB   = 5'd7;
	localparam logic [OP_W-1:0] OP_SC   = 5'd8;
	localparam logic [OP_W-1:0] OP_SCAN = 5'd9;
	localparam logic [OP_W-1:0] OP_IA   = 5'd10;
	localparam logic [OP_W-1:0] OP_IB   = 5'd11;
	localparam logic [OP_W-1:0] OP_IC   = 5'd12;
	localparam logic [OP_W-1:0] OP_MUL  = 5'd13;
	localparam logic [OP_W-1:0] OP_IFIN = 5'd14;
	localparam logic [OP_W-1:0] OP_LAST = 5'd15;
	localparam logic [OP_W-1:0] OP_OUT  = 5'd16;

	typedef struct packed {
		logic            take;
		logic [OP_W-1:0] op;
	} cmd_t;

	typedef struct packed {
		logic grid;
		logic dx_zero;
		logic k_ok;
		logic range_ok;
		logic hit;
		logic scan_end;
		logic k_last;
		logic trivial;
		logic iter_done;
	} st_t;

	function automatic logic [EW-1:0] mag(input logic signed [EW-1:0] v);
		return v[EW-1] ? EW'(-v) : EW'(v);
	endfunction

	function automatic logic [DW-1:0] sat(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] hi;
		logic signed [SW-1:0] lo;
		hi = SW'((64'sd1 <<< (DW - 1)) - 64'sd1);
		lo = -hi - SW'(1);
		if (v > hi) begin
			return hi[DW-1:0];
		end else if (v < lo) begin
			return lo[DW-1:0];
		end
		return v[DW-1:0];
	endfunction

endpackage

// ===== design/tli_ctrl.sv =====
// Sequencer for loads, bracket search, grid division and interpolation steps.
module tli_ctrl import tli_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	output logic       out_valid,
	input  logic       out_stall,
	input  st_t        st,
	output cmd_t       cmd
);

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_GA   = 5'd1;
	localparam logic [4:0] ST_GB   = 5'd2;
	localparam logic [4:0] ST_GC   = 5'd3;
	localparam logic [4:0] ST_GDIV = 5'd4;
	localparam logic [4:0] ST_GFIN = 5'd5;
	localparam logic [4:0] ST_SA   = 5'd6;
	localparam logic [4:0] ST_SB   = 5'd7;
	localparam logic [4:0] ST_SC   = 5'd8;
	localparam logic [4:0] ST_SCAN = 5'd9;
	localparam logic [4:0] ST_IA   = 5'd10;
	localparam logic [4:0] ST_IB   = 5'd11;
	localparam logic [4:0] ST_IC   = 5'd12;
	localparam logic [4:0] ST_MUL  = 5'd13;
	localparam logic [4:0] ST_IDIV = 5'd14;
	localparam logic [4:0] ST_IFIN = 5'd15;
	localparam logic [4:0] ST_LAST = 5'd16;
	localparam logic [4:0] ST_OUT  = 5'd17;

	logic [4:0] state_q;
	logic [4:0] state_nx;
	logic       out_valid_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nx = state_q;
		cmd.op   = OP_NOP;
		cmd.take = in_valid && (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.take && req_type == REQ_QUERY) begin
					state_nx = st.grid ? ST_GA : ST_SA;
				end
			end
			ST_GA: begin
				cmd.op   = OP_GA;
				state_nx = ST_GB;
			end
			ST_GB: begin
				cmd.op   = OP_GB;
				state_nx = ST_GC;
			end
			ST_GC: begin
				cmd.op   = OP_GC;
				state_nx = st.dx_zero ? ST_OUT : ST_GDIV;
			end
			ST_GDIV: begin
				cmd.op = OP_DIV;
				if (st.iter_done) begin
					state_nx = ST_GFIN;
				end
			end
			ST_GFIN: begin
				cmd.op   = OP_GFIN;
				state_nx = st.k_ok ? ST_IA : ST_OUT;
			end
			ST_SA: begin
				cmd.op   = OP_SA;
				state_nx = ST_SB;
			end
			ST_SB: begin
				cmd.op   = OP_SB;
				state_nx = ST_SC;
			end
			ST_SC: begin
				cmd.op   = OP_SC;
				state_nx = st.range_ok ? ST_SCAN : ST_OUT;
			end
			ST_SCAN: begin
				cmd.op = OP_SCAN;
				if (st.hit) begin
					state_nx = ST_IA;
				end else if (st.scan_end) begin
					state_nx = ST_OUT;
				end
			end
			ST_IA: begin
				cmd.op   = OP_IA;
				state_nx = st.k_last ? ST_LAST : ST_IB;
			end
			ST_LAST: begin
				cmd.op   = OP_LAST;
				state_nx = ST_OUT;
			end
			ST_IB: begin
				cmd.op   = OP_IB;
				state_nx = ST_IC;
			end
			ST_IC: begin
				cmd.op   = OP_IC;
				state_nx = st.trivial ? ST_OUT : ST_MUL;
			end
			ST_MUL: begin
				cmd.op = OP_MUL;
				if (st.iter_done) begin
					state_nx = ST_IDIV;
				end
			end
			ST_IDIV: begin
				cmd.op = OP_DIV;
				if (st.iter_done) begin
					state_nx = ST_IFIN;
				end
			end
			ST_IFIN: begin
				cmd.op   = OP_IFIN;
				state_nx = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.op   = OP_OUT;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_OUT) |-> !(out_valid_q && out_stall))
		else $error("result beat overwritten while stalled");

	a_query_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && req_type == REQ_QUERY) |=> (state_q == ST_GA || state_q == ST_SA))
		else $error("query did not start a bracket lookup");

	a_mul_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL && !st.iter_done) |=> (state_q == ST_MUL))
		else $error("multiply left early");

endmodule

// ===== design/tli_dp.sv =====
// Datapath: sample and value tables, config registers, shift-add multiply and divide.
module tli_dp import tli_pkg::*; #(
	parameter int MAX_POINTS = 1024,
	parameter int IW = $clog2(MAX_POINTS),
	parameter int PCW = $clog2(MAX_POINTS + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output st_t                  st,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [PCW-1:0]       cfg_data,
	input  logic [1:0]           req_type,
	input  logic [IW-1:0]        entry_index,
	input  logic signed [DW-1:0] entry_value,
	input  logic signed [DW-1:0] query_point,
	output logic                 found,
	output logic [IW-1:0]        bracket_index,
	output logic signed [DW-1:0] interp_value
);

	localparam logic [PCW-1:0] NMAX = PCW'(MAX_POINTS);

	logic [DW-1:0] xmem [MAX_POINTS];
	logic [DW-1:0] fmem [MAX_POINTS];
	logic [IW-1:0] xaddr;
	logic [IW-1:0] faddr;
	logic [DW-1:0] xrd_q;
	logic [DW-1:0] frd_q;

	logic [PCW-1:0] pc_q;
	logic           grid_q;
	logic           rev_q;

	logic signed [DW-1:0] z_q;
	logic [PCW-1:0]       n_q;
	logic [IW-1:0]        k_q;
	logic [PCW-1:0]       scnt_q;
	logic signed [EW-1:0] a_q;
	logic signed [EW-1:0] fa_q;
	logic signed [EW-1:0] prev_q;
	logic [PW-1:0]        dvd_q;
	logic [EW-1:0]        rem_q;
	logic [EW-1:0]        dvs_q;
	logic [EW-1:0]        mcand_q;
	logic [EW-1:0]        mpl_q;
	logic [CW-1:0]        cnt_q;
	logic                 neg_q;
	logic                 res_found_q;
	logic [IW-1:0]        res_k_q;
	logic [DW-1:0]        res_val_q;
	logic                 found_q;
	logic [IW-1:0]        bk_q;
	logic [DW-1:0]        val_q;

	logic                 wr_ok;
	logic [PCW-1:0]       n_cl;
	logic [PCW-1:0]       n_m1;
	logic [PCW-1:0]       k_e;
	logic [PCW-1:0]       scnt_p1;
	logic [PCW-1:0]       scnt_m1;
	logic signed [EW-1:0] x_e;
	logic signed [EW-1:0] z_e;
	logic signed [EW-1:0] f_e;
	logic signed [EW-1:0] diff_x;
	logic signed [EW-1:0] diff_z;
	logic signed [EW-1:0] diff_f;
	logic [EW:0]          rem_nx;
	logic                 ge;
	logic [EW:0]          rem_sub;
	logic [PW-1:0]        mul_nx;
	logic [EW-1:0]        qm;
	logic signed [SW-1:0] qs;
	logic signed [SW-1:0] sum;
	logic                 big;
	logic [DW-1:0]        sat_max;
	logic [DW-1:0]        sat_min;

	assign wr_ok   = PCW'(entry_index) < NMAX;
	assign n_cl    = (pc_q < PCW'(2)) ? PCW'(2) : ((pc_q > NMAX) ? NMAX : pc_q);
	assign n_m1    = n_q - PCW'(1);
	assign k_e     = PCW'(k_q);
	assign scnt_p1 = scnt_q + PCW'(1);
	assign scnt_m1 = scnt_q - PCW'(1);
	assign x_e     = EW'(signed'(xrd_q));
	assign f_e     = EW'(signed'(frd_q));
	assign z_e     = EW'(z_q);
	assign diff_x  = x_e - a_q;
	assign diff_z  = z_e - a_q;
	assign diff_f  = f_e - fa_q;
	assign rem_nx  = {rem_q, dvd_q[PW-1]};
	assign ge      = rem_nx >= {1'b0, dvs_q};
	assign rem_sub = rem_nx - {1'b0, dvs_q};
	assign mul_nx  = {dvd_q[PW-2:0], 1'b0} + (mpl_q[EW-1] ? PW'(mcand_q) : PW'(0));
	assign qm      = dvd_q[EW-1:0];
	assign qs      = signed'(SW'(dvd_q[EW:0]));
	assign sum     = SW'(fa_q) + (neg_q ? -qs : qs);
	assign big     = |dvd_q[PW-1:EW+1];
	assign sat_max = {1'b0, {(DW-1){1'b1}}};
	assign sat_min = {1'b1, {(DW-1){1'b0}}};

	assign st.grid      = grid_q;
	assign st.dx_zero   = (diff_x == '0);
	assign st.k_ok      = neg_q ? (qm == '0 && rem_q == '0) : (qm < EW'(n_q));
	assign st.range_ok  = !(z_e < x_e) && !(z_e > a_q);
	assign st.hit       = (prev_q <= z_e) && (z_e <= x_e);
	assign st.scan_end  = (scnt_q == n_m1);
	assign st.k_last    = (k_e == n_m1);
	assign st.trivial   = (diff_x == '0) || (diff_z == '0) || (diff_f == '0);
	assign st.iter_done = (cnt_q == CW'(1));

	always_comb begin
		xaddr = '0;
		faddr = '0;
		unique case (cmd.op)
			OP_GB:   xaddr = IW'(1);
			OP_SA:   xaddr = n_m1[IW-1:0];
			OP_SC:   xaddr = IW'(1);
			OP_SCAN: xaddr = scnt_p1[IW-1:0];
			OP_IA: begin
				xaddr = k_q;
				if (st.k_last) begin
					faddr = rev_q ? '0 : n_m1[IW-1:0];
				end else begin
					faddr = rev_q ? IW'(n_m1 - k_e) : k_q;
				end
			end
			OP_IB: begin
				xaddr = IW'(k_e + PCW'(1));
				faddr = rev_q ? IW'(n_m1 - k_e - PCW'(1)) : IW'(k_e + PCW'(1));
			end
			default: begin
				xaddr = '0;
				faddr = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.take && req_type == REQ_LOAD_X && wr_ok) begin
			xmem[entry_index] <= entry_value;
		end
		xrd_q <= xmem[xaddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.take && req_type == REQ_LOAD_F && wr_ok) begin
			fmem[entry_index] <= entry_value;
		end
		frd_q <= fmem[faddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= NMAX;
			grid_q <= 1'b0;
			rev_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POINT_COUNT:  pc_q   <= cfg_data;
				REG_GRID_MODE:    grid_q <= cfg_data[0];
				REG_REVERSE_MODE: rev_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			z_q         <= query_point;
			n_q         <= n_cl;
			res_found_q <= 1'b0;
			res_k_q     <= '0;
			res_val_q   <= '0;
		end
		unique case (cmd.op)
			OP_GB: a_q <= x_e;
			OP_GC: begin
				neg_q <= diff_z[EW-1] ^ diff_x[EW-1];
				dvs_q <= mag(diff_x);
				dvd_q <= {mag(diff_z), EW'(0)};
				rem_q <= '0;
				cnt_q <= GDIV_STEPS;
			end
			OP_DIV: begin
				rem_q <= ge ? rem_sub[EW-1:0] : rem_nx[EW-1:0];
				dvd_q <= {dvd_q[PW-2:0], ge};
				cnt_q <= cnt_q - CW'(1);
			end
			OP_GFIN: k_q <= qm[IW-1:0];
			OP_SB:   a_q <= x_e;
			OP_SC: begin
				prev_q <= x_e;
				scnt_q <= PCW'(1);
			end
			OP_SCAN: begin
				prev_q <= x_e;
				scnt_q <= scnt_p1;
				if (st.hit) begin
					k_q <= scnt_m1[IW-1:0];
				end
			end
			OP_IA: begin
				res_found_q <= 1'b1;
				res_k_q     <= k_q;
			end
			OP_LAST: res_val_q <= frd_q;
			OP_IB: begin
				a_q  <= x_e;
				fa_q <= f_e;
			end
			OP_IC: begin
				res_val_q <= fa_q[DW-1:0];
				neg_q     <= diff_f[EW-1] ^ diff_z[EW-1] ^ diff_x[EW-1];
				mcand_q   <= mag(diff_f);
				mpl_q     <= mag(diff_z);
				dvs_q     <= mag(diff_x);
				dvd_q     <= '0;
				cnt_q     <= MUL_STEPS;
			end
			OP_MUL: begin
				dvd_q <= mul_nx;
				mpl_q <= {mpl_q[EW-2:0], 1'b0};
				if (st.iter_done) begin
					cnt_q <= IDIV_STEPS;
					rem_q <= '0;
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
			OP_IFIN: res_val_q <= big ? (neg_q ? sat_min : sat_max) : sat(sum);
			OP_OUT: begin
				found_q <= res_found_q;
				bk_q    <= res_k_q;
				val_q   <= res_val_q;
			end
			default: ;
		endcase
	end

	assign found         = found_q;
	assign bracket_index = bk_q;
	assign interp_value  = val_q;

endmodule

// ===== design/table_linear_interpolator_unit.sv =====
// Piecewise-linear Q16.16 table interpolator. A load beat (sample point or value) is written
// to its table as it is taken. A query runs through one shared shift-add multiplier and
// restoring divider that handle one bit per cycle, and the tables are memories read one entry
// per cycle. A grid-mode query runs a 33-step grid division, a 33-step multiply and a 66-step
// divide; a search-mode query scans one sample point per cycle for its bracket, then multiplies
// and divides. Queries that miss or hit the last entry skip the multiply and divide, as do those
// whose bracket has zero width or a zero value step or whose point is the bracket's left end.
// The next beat is accepted while a result waits.
module table_linear_interpolator_unit import tli_pkg::*; #(
	parameter int MAX_POINTS = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [1:0]                            req_type,
	input  logic [$clog2(MAX_POINTS)-1:0]         entry_index,
	input  logic signed [DW-1:0]                  entry_value,
	input  logic signed [DW-1:0]                  query_point,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  found,
	output logic [$clog2(MAX_POINTS)-1:0]         bracket_index,
	output logic signed [DW-1:0]                  interp_value,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [1:0]                            cfg_index,
	input  logic [$clog2(MAX_POINTS+1)-1:0]       cfg_data
);

	cmd_t cmd;
	st_t  st;

	assign cfg_ready = 1'b1;

	tli_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	tli_dp #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.req_type      (req_type),
		.entry_index   (entry_index),
		.entry_value   (entry_value),
		.query_point   (query_point),
		.found         (found),
		.bracket_index (bracket_index),
		.interp_value  (interp_value)
	);

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the table linear interpolator: loads, queries and register settings.
module testbench;
	import tli_pkg::*;

	localparam int NPTS = 1024;
	localparam int LIMIT = 3000000;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct {
		logic        found;
		logic [9:0]  k;
		logic [31:0] v;
	} interp_result_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] req_type;
	logic [9:0] entry_index;
	logic signed [31:0] entry_value;
	logic signed [31:0] query_point;
	logic out_valid;
	logic out_stall;
	logic found;
	logic [9:0] bracket_index;
	logic signed [31:0] interp_value;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [10:0] cfg_data;

	logic signed [31:0] x_tab [NPTS];
	logic signed [31:0] f_tab [NPTS];
	logic [10:0] pt_count;
	logic grid_on;
	logic rev_on;

	interp_result_t expected_q [$];
	int errors;
	int cycles;
	int beats_sent;
	int queries_sent;
	int results_seen;
	int stall_left;
	bit no_idle;

	table_linear_interpolator_unit #(.MAX_POINTS(NPTS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .entry_index(entry_index),
		.entry_value(entry_value), .query_point(query_point),
		.out_valid(out_valid), .out_stall(out_stall),
		.found(found), .bracket_index(bracket_index), .interp_value(interp_value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int used_points();
		if (pt_count < 2) begin
			return 2;
		end
		if (pt_count > NPTS) begin
			return NPTS;
		end
		return pt_count;
	endfunction

	function automatic logic [31:0] clip32(input logic signed [131:0] v);
		if (v > 132'sd2147483647) begin
			return 32'h7fffffff;
		end
		if (v < -132'sd2147483648) begin
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	function automatic interp_result_t interpolate_at(input logic signed [31:0] z);
		interp_result_t r;
		int n;
		int k;
		longint x0, dx, num, q, fk, df, xk;
		logic signed [131:0] a, b, p;
		bit hit;
		n = used_points();
		hit = 0;
		k = 0;
		if (grid_on) begin
			x0 = x_tab[0];
			dx = longint'(x_tab[1]) - x0;
			num = longint'(z) - x0;
			if (dx != 0) begin
				q = num / dx;
				if ((num % dx) != 0 && ((num < 0) != (dx < 0))) begin
					q--;
				end
				if (q >= 0 && q < n) begin
					hit = 1;
					k = int'(q);
				end
			end
		end else if (z >= x_tab[0] && z <= x_tab[n-1]) begin
			for (int i = 0; i + 1 < n; i++) begin
				if (z >= x_tab[i] && z <= x_tab[i+1]) begin
					hit = 1;
					k = i;
					break;
				end
			end
		end
		r.found = hit;
		r.k = hit ? 10'(k) : 10'd0;
		r.v = 32'd0;
		if (hit) begin
			if (k + 1 == n) begin
				r.v = rev_on ? f_tab[0] : f_tab[n-1];
			end else begin
				if (rev_on) begin
					fk = f_tab[n-1-k];
					df = longint'(f_tab[n-2-k]) - fk;
				end else begin
					fk = f_tab[k];
					df = longint'(f_tab[k+1]) - fk;
				end
				xk = x_tab[k];
				dx = longint'(x_tab[k+1]) - xk;
				if (dx == 0) begin
					r.v = fk[31:0];
				end else begin
					a = df;
					b = longint'(z) - xk;
					p = a * b;
					p = p / 132'(signed'(dx));
					r.v = clip32(p + 132'(signed'(fk)));
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin
		interp_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (found !== e.found) begin
					$error("found: expected %0d actual %0d", e.found, found);
					errors++;
				end
				if (bracket_index !== e.k) begin
					$error("bracket_index: expected %0d actual %0d", e.k, bracket_index);
					errors++;
				end
				if (interp_value !== e.v) begin
					$error("interp_value: expected %0d actual %0d", $signed(e.v), interp_value);
					errors++;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (out_valid && !out_stall) begin
			stall_left <= no_idle ? 0 : $urandom_range(0, 18);
			out_stall <= !no_idle && ($urandom_range(0, 1) != 0);
		end else if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else begin
			stall_left <= 0;
			out_stall <= 1'b0;
		end
	end

	task automatic send_beat(input logic [1:0] kind, input logic [9:0] idx,
			input logic signed [31:0] val, input logic signed [31:0] z);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		entry_index <= idx;
		entry_value <= val;
		query_point <= z;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		beats_sent++;
		case (kind)
			REQ_LOAD_X: begin
				x_tab[idx] = val;
			end
			REQ_LOAD_F: begin
				f_tab[idx] = val;
			end
			REQ_QUERY: begin
				queries_sent++;
				expected_q.push_back(interpolate_at(z));
			end
			default: begin
			end
		endcase
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [10:0] data);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_POINT_COUNT: begin
				pt_count = data;
			end
			REG_GRID_MODE: begin
				grid_on = data[0];
			end
			REG_REVERSE_MODE: begin
				rev_on = data[0];
			end
			default: begin
			end
		endcase
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			default: return $urandom;
		endcase
	endfunction

	// shape: 0 even grid, 1 sorted with repeats, 2 arbitrary
	task automatic load_tables(input int n, input int shape);
		longint step, base, cur;
		for (int i = 0; i < n; i++) begin
			send_beat(REQ_LOAD_F, 10'(i), rand_word(), $urandom);
		end
		step = $urandom_range(1, 32'h3fffff / n) * ($urandom_range(0, 3) == 0 ? -1 : 1);
		base = longint'($signed($urandom)) / 4;
		cur = longint'($signed($urandom_range(0, 32'hffff))) - 32'h40000000;
		for (int i = 0; i < n; i++) begin
			if (shape == 0) begin
				send_beat(REQ_LOAD_X, 10'(i), 32'(base + i * step), $urandom);
			end else if (shape == 1) begin
				send_beat(REQ_LOAD_X, 10'(i), 32'(cur), $urandom);
				if ($urandom_range(0, 4) != 0) begin
					cur += $urandom_range(0, 32'h7fffff / n);
				end
			end else begin
				send_beat(REQ_LOAD_X, 10'(i), rand_word(), $urandom);
			end
		end
	endtask

	// load only the bracket entries that a grid query in bracket k reads, forward and reversed
	task automatic load_bracket(input int k, input longint base, input longint step);
		send_beat(REQ_LOAD_X, 10'(k), 32'(base + k * step), $urandom);
		send_beat(REQ_LOAD_F, 10'(k), rand_word(), $urandom);
		send_beat(REQ_LOAD_F, 10'(NPTS - 1 - k), rand_word(), $urandom);
		if (k + 1 < NPTS) begin
			send_beat(REQ_LOAD_X, 10'(k + 1), 32'(base + (k + 1) * step), $urandom);
			send_beat(REQ_LOAD_F, 10'(k + 1), rand_word(), $urandom);
			send_beat(REQ_LOAD_F, 10'(NPTS - 2 - k), rand_word(), $urandom);
		end
	endtask

	function automatic logic [31:0] pick_query();
		int n;
		longint lo, hi, t;
		n = used_points();
		lo = x_tab[0];
		hi = x_tab[n-1];
		if (grid_on) begin
			hi = lo + (longint'(x_tab[1]) - lo) * n;
		end
		if (lo > hi) begin
			t = lo;
			lo = hi;
			hi = t;
		end
		case ($urandom_range(0, 9))
			0, 1: return $urandom;
			2: return x_tab[$urandom_range(0, n - 1)];
			3: return 32'(lo - $urandom_range(0, 3));
			default: begin
				t = lo + longint'({$urandom, $urandom} % (hi - lo + 2));
				if (t > 64'sh7fffffff) begin
					t = 64'sh7fffffff;
				end
				if (t < -64'sh80000000) begin
					t = -64'sh80000000;
				end
				return 32'(t);
			end
		endcase
	endfunction

	task automatic test_full_table();
		longint base, step;
		int ks [4];
		step = $urandom_range(1, 32'h3fffff / NPTS);
		base = longint'($signed($urandom)) / 4;
		ks = '{0, 511, NPTS - 2, NPTS - 1};
		write_reg(REG_GRID_MODE, 11'd1);
		foreach (ks[j]) begin
			load_bracket(ks[j], base, step);
		end
		for (int r = 0; r < 2; r++) begin
			foreach (ks[j]) begin
				send_beat(REQ_QUERY, 0, 0,
					32'(base + ks[j] * step + $urandom_range(0, step - 1)));
			end
			send_beat(REQ_QUERY, 0, 0, 32'(base - 1));
			send_beat(REQ_QUERY, 0, 0, 32'(base + NPTS * step));
			send_beat(REQ_QUERY, 0, 0, 32'h7fffffff);
			send_beat(REQ_QUERY, 0, 0, 32'h80000000);
			send_beat(REQ_UNUSED, 10'h3ff, 32'hffffffff, 32'hffffffff);
			write_reg(REG_REVERSE_MODE, 11'd1);
		end
		write_reg(REG_POINT_COUNT, 11'd2047);
		send_beat(REQ_QUERY, 0, 0, 32'(base + 511 * step));
	endtask

	task automatic test_small_counts();
		write_reg(REG_GRID_MODE, 11'd0);
		write_reg(REG_POINT_COUNT, 11'd0);
		load_tables(2, 2);
		send_beat(REQ_QUERY, 0, 0, x_tab[1]);
		send_beat(REQ_QUERY, 0, 0, pick_query());
		write_reg(REG_POINT_COUNT, 11'd1);
		send_beat(REQ_QUERY, 0, 0, x_tab[0]);
		write_reg(REG_REVERSE_MODE, 11'd0);
		write_reg(REG_POINT_COUNT, 11'd2);
		send_beat(REQ_QUERY, 0, 0, pick_query());
	endtask

	task automatic test_flat_steps();
		write_reg(REG_POINT_COUNT, 11'd4);
		for (int i = 0; i < 4; i++) begin
			send_beat(REQ_LOAD_F, 10'(i), rand_word(), 0);
		end
		send_beat(REQ_LOAD_X, 0, 32'sd65536, 0);
		send_beat(REQ_LOAD_X, 1, 32'sd65536, 0);
		send_beat(REQ_LOAD_X, 2, 32'sd131072, 0);
		send_beat(REQ_LOAD_X, 3, 32'sd131072, 0);
		send_beat(REQ_QUERY, 0, 0, 32'sd65536);
		send_beat(REQ_QUERY, 0, 0, 32'sd131072);
		write_reg(REG_GRID_MODE, 11'd1);
		send_beat(REQ_QUERY, 0, 0, 32'sd65536);
		write_reg(REG_GRID_MODE, 11'd0);
	endtask

	task automatic test_random_mix();
		int n;
		int kind;
		while (beats_sent < 340) begin
			case ($urandom_range(0, 9))
				0: n = $urandom_range(41, 64);
				1: n = 2;
				2: n = 3;
				default: n = $urandom_range(2, 40);
			endcase
			write_reg(REG_POINT_COUNT, 11'(n));
			write_reg(REG_GRID_MODE, 11'($urandom_range(0, 1)));
			write_reg(REG_REVERSE_MODE, 11'($urandom_range(0, 1)));
			no_idle = ($urandom_range(0, 3) == 0);
			load_tables(n, grid_on ? ($urandom_range(0, 3) == 0 ? 2 : 0) :
				$urandom_range(0, 2));
			for (int i = 0; i < 25; i++) begin
				kind = $urandom_range(0, 19);
				if (kind == 0) begin
					send_beat(REQ_UNUSED, 10'($urandom), $urandom, $urandom);
				end else if (kind < 3) begin
					send_beat(kind == 1 ? REQ_LOAD_F : REQ_LOAD_X,
						10'($urandom_range(0, n - 1)), rand_word(), $urandom);
				end else begin
					send_beat(REQ_QUERY, 10'($urandom), $urandom, pick_query());
				end
				if (i == 12 && $urandom_range(0, 3) == 0) begin
					drain();
				end
			end
			no_idle = 0;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_LOAD_X;
		entry_index = '0;
		entry_value = '0;
		query_point = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_POINT_COUNT;
		cfg_data = '0;
		pt_count = 11'd1024;
		grid_on = 1'b0;
		rev_on = 1'b0;
		errors = 0;
		cycles = 0;
		beats_sent = 0;
		queries_sent = 0;
		results_seen = 0;
		no_idle = 0;
		foreach (x_tab[i]) begin
			x_tab[i] = '0;
			f_tab[i] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_full_table();
		test_small_counts();
		test_flat_steps();
		test_random_mix();
		drain();
		repeat (200) @(posedge clk);
		$display("Covered %0d beats, %0d queries, %0d results checked",
			beats_sent, queries_sent, results_seen);
		$display("Counts 2..64 in search and grid, a clamped 1024-entry grid, forward and reversed");
		if (errors == 0 && expected_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, expected_q.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/tli_pkg.sv
design/tli_ctrl.sv
design/tli_dp.sv
design/table_linear_interpolator_unit.sv
tb/testbench.sv
